// File: hw/rtl/vpvg_pkg.sv
// Shared types and constants of the vanishing point vote grid.
`timescale 1ns / 1ps

package vpvg_pkg;

   localparam int COORD_W = 10;
   localparam int CFG_W = 7;
   localparam int VOTE_W = 11;
   localparam int DIFF_W = 11;
   localparam int PROD_W = 22;
   localparam int CROSS_W = 22;
   localparam int NUM_W = 23;
   localparam int PT_W = 36;
   localparam int DIV_W = CFG_W + CROSS_W;
   localparam int SEG_W = 4 * COORD_W;
   localparam int ANG_W = 31;
   localparam int TAN5_Q20 = 91739;
   localparam int TAN10_Q20 = 184892;
   localparam int Q20_SHIFT = 20;

   localparam logic [VOTE_W-1:0] VOTE_MAX = 11'd2047;
   localparam logic [CFG_W-1:0] CELL_WIDTH_RESET = 7'd19;
   localparam logic [CFG_W-1:0] CELL_HEIGHT_RESET = 7'd15;

   localparam logic REG_CELL_WIDTH = 1'b0;
   localparam logic REG_CELL_HEIGHT = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECIDE, ST_RD, ST_DIFF, ST_MUL1, ST_CROSS, ST_MUL2,
      ST_POINT, ST_CHECK, ST_DIV, ST_VADDR, ST_VRD, ST_VWR, ST_NEXT, ST_SCAN,
      ST_TAIL, ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic frame_init;
      logic div_init;
      logic div_step;
      logic vote_wr;
      logic pair_next;
      logic clear_wr;
      logic scan_rd;
      logic frame_clear;
   } cmd_type;

   typedef struct packed {
      logic addr_last;
      logic vote_ok;
      logic cross_zero;
      logic in_range;
      logic div_done;
      logic pair_last;
   } status_type;

endpackage

// File: hw/rtl/vpvg_ctrl.sv
// Sequencing state machine of the vanishing point vote grid.
`timescale 1ns / 1ps

module vpvg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 frame_last,
   input  vpvg_pkg::status_type status,
   output vpvg_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   vpvg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vpvg_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vpvg_pkg::ST_CLEAR: begin
            if (status.addr_last) state_in = vpvg_pkg::ST_IDLE;
         end
         vpvg_pkg::ST_IDLE: begin
            if (start && frame_last) state_in = vpvg_pkg::ST_DECIDE;
         end
         vpvg_pkg::ST_DECIDE: begin
            state_in = status.vote_ok ? vpvg_pkg::ST_RD : vpvg_pkg::ST_SCAN;
         end
         vpvg_pkg::ST_RD:    state_in = vpvg_pkg::ST_DIFF;
         vpvg_pkg::ST_DIFF:  state_in = vpvg_pkg::ST_MUL1;
         vpvg_pkg::ST_MUL1:  state_in = vpvg_pkg::ST_CROSS;
         vpvg_pkg::ST_CROSS: state_in = vpvg_pkg::ST_MUL2;
         vpvg_pkg::ST_MUL2: begin
            state_in = status.cross_zero ? vpvg_pkg::ST_NEXT : vpvg_pkg::ST_POINT;
         end
         vpvg_pkg::ST_POINT: state_in = vpvg_pkg::ST_CHECK;
         vpvg_pkg::ST_CHECK: begin
            state_in = status.in_range ? vpvg_pkg::ST_DIV : vpvg_pkg::ST_NEXT;
         end
         vpvg_pkg::ST_DIV: begin
            if (status.div_done) state_in = vpvg_pkg::ST_VADDR;
         end
         vpvg_pkg::ST_VADDR: state_in = vpvg_pkg::ST_VRD;
         vpvg_pkg::ST_VRD:   state_in = vpvg_pkg::ST_VWR;
         vpvg_pkg::ST_VWR:   state_in = vpvg_pkg::ST_NEXT;
         vpvg_pkg::ST_NEXT: begin
            state_in = status.pair_last ? vpvg_pkg::ST_SCAN : vpvg_pkg::ST_RD;
         end
         vpvg_pkg::ST_SCAN: begin
            if (status.addr_last) state_in = vpvg_pkg::ST_TAIL;
         end
         vpvg_pkg::ST_TAIL: state_in = vpvg_pkg::ST_RESP;
         vpvg_pkg::ST_RESP: state_in = vpvg_pkg::ST_IDLE;
         default:            state_in = vpvg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         vpvg_pkg::ST_CLEAR: cmd.clear_wr = 1'b1;
         vpvg_pkg::ST_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         vpvg_pkg::ST_DECIDE: cmd.frame_init = 1'b1;
         vpvg_pkg::ST_CHECK:  cmd.div_init = 1'b1;
         vpvg_pkg::ST_DIV:    cmd.div_step = 1'b1;
         vpvg_pkg::ST_VWR:    cmd.vote_wr = 1'b1;
         vpvg_pkg::ST_NEXT:   cmd.pair_next = 1'b1;
         vpvg_pkg::ST_SCAN:   cmd.scan_rd = 1'b1;
         vpvg_pkg::ST_RESP: begin
            cmd.frame_clear = 1'b1;
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: hw/rtl/vpvg_datapath.sv
// Line store, intersection arithmetic, cell divider and vote grid memory.
`timescale 1ns / 1ps

module vpvg_datapath #(
   parameter int MAX_LINES = 64,
   parameter int GRID_COLS = 33,
   parameter int GRID_ROWS = 23
) (
   input  logic                 clock,
   input  logic                 reset,
   input  vpvg_pkg::cmd_type    cmd,
   output vpvg_pkg::status_type status,
   input  logic [9:0]           req_x_start,
   input  logic [9:0]           req_y_start,
   input  logic [9:0]           req_x_end,
   input  logic [9:0]           req_y_end,
   input  logic                 req_segment_valid,
   input  logic                 csr_valid,
   input  logic                 csr_index,
   input  logic [6:0]           csr_wdata,
   output logic                 rsp_found,
   output logic [5:0]           rsp_cell_col,
   output logic [4:0]           rsp_cell_row,
   output logic [10:0]          rsp_vote_count,
   output logic [6:0]           rsp_kept_lines,
   output logic                 rsp_overflow
);

   localparam int IW = $clog2(MAX_LINES);
   localparam int LCW = $clog2(MAX_LINES + 1);
   localparam int CW = $clog2(GRID_COLS);
   localparam int RW = $clog2(GRID_ROWS);
   localparam int QB = (CW > RW) ? CW : RW;
   localparam int KW = $clog2(QB + 1);
   localparam int CELLS = GRID_COLS * GRID_ROWS;
   localparam int GAW = $clog2(CELLS);
   localparam int WCW = vpvg_pkg::CFG_W + $clog2(GRID_COLS);
   localparam int HRW = vpvg_pkg::CFG_W + $clog2(GRID_ROWS);
   localparam int RMW = vpvg_pkg::PT_W - 1;

   // Configuration.
   logic [vpvg_pkg::CFG_W-1:0] cell_w_ff, cell_h_ff;
   logic [WCW-1:0] wc_ff;
   logic [HRW-1:0] hr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_w_ff <= vpvg_pkg::CELL_WIDTH_RESET;
         cell_h_ff <= vpvg_pkg::CELL_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            vpvg_pkg::REG_CELL_WIDTH:  cell_w_ff <= csr_wdata;
            vpvg_pkg::REG_CELL_HEIGHT: cell_h_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      wc_ff <= WCW'(cell_w_ff) * WCW'(GRID_COLS);
      hr_ff <= HRW'(cell_h_ff) * HRW'(GRID_ROWS);
   end

   // Angle filter on the incoming segment.
   logic signed [vpvg_pkg::DIFF_W-1:0] f_dx, f_dy;
   logic [vpvg_pkg::COORD_W-1:0] f_ax, f_ay;
   logic [vpvg_pkg::ANG_W-1:0] f_ax_sh, f_ay_sh, f_ax_t5, f_ay_t10;
   logic f_keep;

   always_comb begin
      f_dx = $signed({1'b0, req_x_end}) - $signed({1'b0, req_x_start});
      f_dy = $signed({1'b0, req_y_start}) - $signed({1'b0, req_y_end});
      f_ax = vpvg_pkg::COORD_W'(f_dx < 0 ? -f_dx : f_dx);
      f_ay = vpvg_pkg::COORD_W'(f_dy < 0 ? -f_dy : f_dy);
      f_ax_sh = vpvg_pkg::ANG_W'(f_ax) << vpvg_pkg::Q20_SHIFT;
      f_ay_sh = vpvg_pkg::ANG_W'(f_ay) << vpvg_pkg::Q20_SHIFT;
      f_ax_t5 = vpvg_pkg::ANG_W'(f_ax) * vpvg_pkg::ANG_W'(vpvg_pkg::TAN5_Q20);
      f_ay_t10 = vpvg_pkg::ANG_W'(f_ay) * vpvg_pkg::ANG_W'(vpvg_pkg::TAN10_Q20);
      f_keep = req_segment_valid && !(f_ax == '0 && f_ay == '0)
               && !(f_ax != '0 && f_ay_sh < f_ax_t5) && !(f_ax_sh < f_ay_t10);
   end

   // Line store and pair counters.
   logic [vpvg_pkg::SEG_W-1:0] line_mem [MAX_LINES];
   logic [vpvg_pkg::SEG_W-1:0] a_ff, b_ff;
   logic [LCW-1:0] line_count_ff;
   logic overflow_ff;
   logic [IW-1:0] i_ff, j_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.frame_clear) begin
         line_count_ff <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.load && f_keep) begin
         if (line_count_ff == LCW'(MAX_LINES)) begin
            overflow_ff <= 1'b1;
         end else begin
            line_count_ff <= line_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && f_keep && line_count_ff != LCW'(MAX_LINES)) begin
         line_mem[line_count_ff[IW-1:0]] <=
            {req_x_start, req_y_start, req_x_end, req_y_end};
      end
      a_ff <= line_mem[i_ff];
      b_ff <= line_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         j_ff <= '0;
      end else if (cmd.frame_init) begin
         i_ff <= '0;
         j_ff <= IW'(1);
      end else if (cmd.pair_next) begin
         if (LCW'(j_ff) == line_count_ff - 1'b1) begin
            i_ff <= i_ff + 1'b1;
            j_ff <= i_ff + IW'(2);
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
   end

   // Intersection pipeline.
   logic [vpvg_pkg::COORD_W-1:0] x0_ff, y0_ff;
   logic signed [vpvg_pkg::DIFF_W-1:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff, ox_ff, oy_ff;
   logic signed [vpvg_pkg::PROD_W-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [vpvg_pkg::NUM_W-1:0] c_in, n_in, num_ff;
   logic [vpvg_pkg::CROSS_W-1:0] cross_ff;
   logic [31:0] mx0_ff, my0_ff;
   logic signed [33:0] mdx_ff, mdy_ff;
   logic [vpvg_pkg::DIV_W-1:0] dcol_ff, drow_ff;
   logic [WCW+vpvg_pkg::CROSS_W-1:0] lim_x_ff;
   logic [HRW+vpvg_pkg::CROSS_W-1:0] lim_y_ff;
   logic signed [vpvg_pkg::PT_W-1:0] nx_ff, ny_ff;

   assign c_in = p1_ff - p2_ff;
   assign n_in = p3_ff - p4_ff;

   always_ff @(posedge clock) begin
      x0_ff <= a_ff[39:30];
      y0_ff <= a_ff[29:20];
      d1x_ff <= $signed({1'b0, a_ff[19:10]}) - $signed({1'b0, a_ff[39:30]});
      d1y_ff <= $signed({1'b0, a_ff[9:0]}) - $signed({1'b0, a_ff[29:20]});
      d2x_ff <= $signed({1'b0, b_ff[19:10]}) - $signed({1'b0, b_ff[39:30]});
      d2y_ff <= $signed({1'b0, b_ff[9:0]}) - $signed({1'b0, b_ff[29:20]});
      ox_ff <= $signed({1'b0, b_ff[39:30]}) - $signed({1'b0, a_ff[39:30]});
      oy_ff <= $signed({1'b0, b_ff[29:20]}) - $signed({1'b0, a_ff[29:20]});
      p1_ff <= d1x_ff * d2y_ff;
      p2_ff <= d1y_ff * d2x_ff;
      p3_ff <= ox_ff * d2y_ff;
      p4_ff <= oy_ff * d2x_ff;
      cross_ff <= vpvg_pkg::CROSS_W'(c_in < 0 ? -c_in : c_in);
      num_ff <= (c_in < 0) ? -n_in : n_in;
      mx0_ff <= x0_ff * cross_ff;
      my0_ff <= y0_ff * cross_ff;
      mdx_ff <= d1x_ff * num_ff;
      mdy_ff <= d1y_ff * num_ff;
      dcol_ff <= cell_w_ff * cross_ff;
      drow_ff <= cell_h_ff * cross_ff;
      lim_x_ff <= wc_ff * cross_ff;
      lim_y_ff <= hr_ff * cross_ff;
      nx_ff <= $signed({4'b0, mx0_ff}) + mdx_ff;
      ny_ff <= $signed({4'b0, my0_ff}) + mdy_ff;
   end

   // Restoring divider for the cell indexes, one quotient bit per cycle.
   logic [RMW-1:0] rem_x_ff, rem_y_ff, tx, ty;
   logic [QB-1:0] q_col_ff, q_row_ff;
   logic [KW-1:0] k_ff;
   logic bx, by;

   assign tx = RMW'(dcol_ff) << k_ff;
   assign ty = RMW'(drow_ff) << k_ff;
   assign bx = rem_x_ff >= tx;
   assign by = rem_y_ff >= ty;

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_x_ff <= nx_ff[RMW-1:0];
         rem_y_ff <= ny_ff[RMW-1:0];
         q_col_ff <= '0;
         q_row_ff <= '0;
         k_ff <= KW'(QB - 1);
      end else if (cmd.div_step) begin
         if (bx) rem_x_ff <= rem_x_ff - tx;
         if (by) rem_y_ff <= rem_y_ff - ty;
         q_col_ff <= QB'({q_col_ff, bx});
         q_row_ff <= QB'({q_row_ff, by});
         k_ff <= k_ff - 1'b1;
      end
   end

   // Vote grid memory, scan and clear.
   logic [vpvg_pkg::VOTE_W-1:0] grid_mem [CELLS];
   logic [vpvg_pkg::VOTE_W-1:0] grid_rd_ff, grid_wdata;
   logic [GAW-1:0] vaddr_ff, scan_addr_ff, grid_raddr, grid_waddr;
   logic [CW-1:0] scan_col_ff, sc_col_ff, best_col_ff;
   logic [RW-1:0] scan_row_ff, sc_row_ff, best_row_ff;
   logic [vpvg_pkg::VOTE_W-1:0] best_ff;
   logic cmp_en_ff, grid_we, addr_last;

   assign addr_last = scan_addr_ff == GAW'(CELLS - 1);
   assign grid_raddr = cmd.scan_rd ? scan_addr_ff : vaddr_ff;
   assign grid_waddr = cmd.vote_wr ? vaddr_ff : scan_addr_ff;
   assign grid_we = cmd.vote_wr || cmd.scan_rd || cmd.clear_wr;
   assign grid_wdata = !cmd.vote_wr ? '0 :
                       (grid_rd_ff == vpvg_pkg::VOTE_MAX) ? grid_rd_ff : grid_rd_ff + 1'b1;

   always_ff @(posedge clock) begin
      vaddr_ff <= GAW'(int'(CW'(q_col_ff)) * GRID_ROWS + int'(RW'(q_row_ff)));
      grid_rd_ff <= grid_mem[grid_raddr];
      if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
      if (cmd.scan_rd) begin
         sc_col_ff <= scan_col_ff;
         sc_row_ff <= scan_row_ff;
      end
      if (cmd.frame_init) begin
         best_ff <= '0;
         best_col_ff <= '0;
         best_row_ff <= '0;
      end else if (cmp_en_ff && grid_rd_ff > best_ff) begin
         best_ff <= grid_rd_ff;
         best_col_ff <= sc_col_ff;
         best_row_ff <= sc_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
         scan_col_ff <= '0;
         scan_row_ff <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         cmp_en_ff <= cmd.scan_rd;
         if (cmd.frame_init || ((cmd.scan_rd || cmd.clear_wr) && addr_last)) begin
            scan_addr_ff <= '0;
            scan_col_ff <= '0;
            scan_row_ff <= '0;
         end else if (cmd.scan_rd || cmd.clear_wr) begin
            scan_addr_ff <= scan_addr_ff + 1'b1;
            if (scan_row_ff == RW'(GRID_ROWS - 1)) begin
               scan_row_ff <= '0;
               scan_col_ff <= scan_col_ff + 1'b1;
            end else begin
               scan_row_ff <= scan_row_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      status.addr_last = addr_last;
      status.vote_ok = line_count_ff > LCW'(1) && cell_w_ff != '0 && cell_h_ff != '0;
      status.cross_zero = cross_ff == '0;
      status.in_range = nx_ff > 0 && ny_ff > 0
                        && nx_ff < $signed(vpvg_pkg::PT_W'(lim_x_ff))
                        && ny_ff < $signed(vpvg_pkg::PT_W'(lim_y_ff));
      status.div_done = k_ff == '0;
      status.pair_last = LCW'(i_ff) == line_count_ff - LCW'(2)
                         && LCW'(j_ff) == line_count_ff - 1'b1;
   end

   assign rsp_found = best_ff != '0;
   assign rsp_cell_col = 6'(best_col_ff);
   assign rsp_cell_row = 5'(best_row_ff);
   assign rsp_vote_count = best_ff;
   assign rsp_kept_lines = 7'(line_count_ff);
   assign rsp_overflow = overflow_ff;

endmodule

// File: hw/rtl/vanishing_point_vote_grid_top.sv
// Top level of the vanishing point vote grid.
`timescale 1ns / 1ps

// An item without frame_last is taken while the block stays idle. The item
// with frame_last starts the voting pass: a decide state first, then each kept
// pair goes through the shared intersection unit, in states RD, DIFF, MUL1,
// CROSS and MUL2 for a parallel pair, plus POINT and CHECK for a point outside
// the grid, plus the divider steps, VADDR, VRD and VWR for a pair that votes,
// each pair ending in NEXT; the grid memory's one read and one write port then
// set the scan at one cell per cycle, followed by TAIL and the one-cycle
// rsp_valid strobe. After reset a clearing pass over GRID_COLS*GRID_ROWS cells
// (759 by default) runs with busy high. The receiver cannot hold off results.
module vanishing_point_vote_grid_top #(
   parameter int MAX_LINES = 64,
   parameter int GRID_COLS = 33,
   parameter int GRID_ROWS = 23
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [9:0]  req_x_start,
   input  logic [9:0]  req_y_start,
   input  logic [9:0]  req_x_end,
   input  logic [9:0]  req_y_end,
   input  logic        req_segment_valid,
   input  logic        req_frame_last,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [5:0]  rsp_cell_col,
   output logic [4:0]  rsp_cell_row,
   output logic [10:0] rsp_vote_count,
   output logic [6:0]  rsp_kept_lines,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata
);

   vpvg_pkg::cmd_type cmd;
   vpvg_pkg::status_type status;

   assign csr_ready = 1'b1;

   vpvg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .frame_last (req_frame_last),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   vpvg_datapath #(
      .MAX_LINES (MAX_LINES),
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_x_start       (req_x_start),
      .req_y_start       (req_y_start),
      .req_x_end         (req_x_end),
      .req_y_end         (req_y_end),
      .req_segment_valid (req_segment_valid),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_found         (rsp_found),
      .rsp_cell_col      (rsp_cell_col),
      .rsp_cell_row      (rsp_cell_row),
      .rsp_vote_count    (rsp_vote_count),
      .rsp_kept_lines    (rsp_kept_lines),
      .rsp_overflow      (rsp_overflow)
   );

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");

   a_found_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_vote_count != 11'd0)))
      else $error("found flag disagrees with vote count");

   a_empty_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_cell_col == 6'd0 && rsp_cell_row == 5'd0))
      else $error("cell reported without votes");

endmodule
